// ----- rtl/core/u8tr_pkg.sv -----
// ----------------------------------------------------------------------------
// u8tr_pkg
// Types and constants shared by the 8N1 UART transmitter/receiver.
// ----------------------------------------------------------------------------
package u8tr_pkg;

    localparam int unsigned BAUD_DIV_W = 16;
    localparam int unsigned RX_PHASE_W = 17;
    localparam int unsigned CNT_W      = 4;

    localparam logic [BAUD_DIV_W-1:0] BAUD_DIV_RST   = 16'd1667;
    localparam logic [CNT_W-1:0]      TX_FRAME_BITS  = 4'd10;
    localparam logic [CNT_W-1:0]      TX_START_SLOT  = 4'd9;
    localparam logic [CNT_W-1:0]      TX_STOP_SLOT   = 4'd0;
    localparam logic [CNT_W-1:0]      RX_DATA_BITS   = 4'd8;

    typedef enum logic {
        KIND_TICK  = 1'b0,
        KIND_OFFER = 1'b1
    } t_kind;

    typedef struct packed {
        logic       kind;
        logic       rx_level;
        logic [7:0] tx_byte;
    } t_in_item;

    typedef struct packed {
        logic       tx_line;
        logic       tx_busy;
        logic       tx_dropped;
        logic       rx_valid;
        logic [7:0] rx_byte;
    } t_out_item;

endpackage

// ----- rtl/core/u8tr_engine.sv -----
// ----------------------------------------------------------------------------
// u8tr_engine
// Transmit bit clock, frame shifter and receive sampler; one step per i_step, for tick and offer items alike.
// ----------------------------------------------------------------------------
module u8tr_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_step,
    input  u8tr_pkg::t_in_item   i_item,
    output u8tr_pkg::t_out_item  o_result
);
    import u8tr_pkg::*;

    logic [BAUD_DIV_W-1:0] r_baud_div;
    logic [BAUD_DIV_W-1:0] r_tx_phase,     n_tx_phase;
    logic [CNT_W-1:0]      r_tx_bits_left, n_tx_bits_left;
    logic [7:0]            r_tx_shift,     n_tx_shift;
    logic                  r_tx_level,     n_tx_level;
    logic                  r_rx_active,    n_rx_active;
    logic [RX_PHASE_W-1:0] r_rx_phase,     n_rx_phase;
    logic [CNT_W-1:0]      r_rx_bit_index, n_rx_bit_index;
    logic [7:0]            r_rx_shift,     n_rx_shift;
    logic                  r_rx_prev,      n_rx_prev;

    logic [BAUD_DIV_W:0]   tx_next;
    logic                  dropped;
    logic                  rx_done;
    logic [7:0]            rx_data;

    always_comb begin
        n_tx_phase     = r_tx_phase;
        n_tx_bits_left = r_tx_bits_left;
        n_tx_shift     = r_tx_shift;
        n_tx_level     = r_tx_level;
        dropped        = 1'b0;

        if (i_item.kind == KIND_OFFER) begin
            if (r_tx_bits_left != '0) begin
                dropped = 1'b1;
            end else begin
                n_tx_shift     = i_item.tx_byte;
                n_tx_bits_left = TX_FRAME_BITS;
            end
        end

        tx_next = {1'b0, r_tx_phase} + {{BAUD_DIV_W{1'b0}}, 1'b1};
        if (tx_next >= {1'b0, r_baud_div}) begin
            n_tx_phase = '0;
            if (n_tx_bits_left != '0) begin
                n_tx_bits_left = n_tx_bits_left - 1'b1;
                if (n_tx_bits_left == TX_START_SLOT) begin
                    n_tx_level = 1'b0;
                end else if (n_tx_bits_left == TX_STOP_SLOT) begin
                    n_tx_level = 1'b1;
                end else begin
                    n_tx_level = n_tx_shift[0];
                    n_tx_shift = {1'b0, n_tx_shift[7:1]};
                end
            end
        end else begin
            n_tx_phase = tx_next[BAUD_DIV_W-1:0];
        end
    end

    always_comb begin
        n_rx_active    = r_rx_active;
        n_rx_phase     = r_rx_phase;
        n_rx_bit_index = r_rx_bit_index;
        n_rx_shift     = r_rx_shift;
        n_rx_prev      = i_item.rx_level;
        rx_done        = 1'b0;
        rx_data        = '0;

        if (r_rx_active) begin
            if (r_rx_phase > {{(RX_PHASE_W-1){1'b0}}, 1'b1}) begin
                n_rx_phase = r_rx_phase - 1'b1;
            end else begin
                n_rx_phase = {1'b0, r_baud_div};
                if (r_rx_bit_index < RX_DATA_BITS) begin
                    n_rx_shift[r_rx_bit_index[2:0]] = r_rx_shift[r_rx_bit_index[2:0]]
                                                    | i_item.rx_level;
                    n_rx_bit_index = r_rx_bit_index + 1'b1;
                end else begin
                    rx_done     = 1'b1;
                    rx_data     = r_rx_shift;
                    n_rx_active = 1'b0;
                end
            end
        end else if (r_rx_prev && !i_item.rx_level) begin
            n_rx_active    = 1'b1;
            n_rx_phase     = {1'b0, r_baud_div} + {2'b00, r_baud_div[BAUD_DIV_W-1:1]};
            n_rx_bit_index = '0;
            n_rx_shift     = '0;
        end
    end

    always_comb begin
        o_result.tx_line    = n_tx_level;
        o_result.tx_busy    = (n_tx_bits_left != '0);
        o_result.tx_dropped = dropped;
        o_result.rx_valid   = rx_done;
        o_result.rx_byte    = rx_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baud_div <= BAUD_DIV_RST;
        end else if (i_cfg_we) begin
            r_baud_div <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_phase     <= '0;
            r_tx_bits_left <= '0;
            r_tx_shift     <= '0;
            r_tx_level     <= 1'b1;
            r_rx_active    <= 1'b0;
            r_rx_phase     <= '0;
            r_rx_bit_index <= '0;
            r_rx_shift     <= '0;
            r_rx_prev      <= 1'b1;
        end else if (i_step) begin
            r_tx_phase     <= n_tx_phase;
            r_tx_bits_left <= n_tx_bits_left;
            r_tx_shift     <= n_tx_shift;
            r_tx_level     <= n_tx_level;
            r_rx_active    <= n_rx_active;
            r_rx_phase     <= n_rx_phase;
            r_rx_bit_index <= n_rx_bit_index;
            r_rx_shift     <= n_rx_shift;
            r_rx_prev      <= n_rx_prev;
        end
    end

    a_tx_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_bits_left <= TX_FRAME_BITS)
        else $error("tx bit count out of range");

    a_rx_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_bit_index <= RX_DATA_BITS)
        else $error("rx bit index out of range");

    a_rx_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && rx_done) |=> !r_rx_active)
        else $error("receiver still active after completing a byte");

endmodule

// ----- rtl/core/uart_8n1_tx_rx.sv -----
// ----------------------------------------------------------------------------
// uart_8n1_tx_rx
// Full-duplex 8N1 UART stepped once per accepted transaction, tick or offer.
// Results are registered. Throughput: one transaction per cycle while
// the skid entry is empty; a two-entry output buffer keeps input acceptance
// going while one result waits downstream.
// Reset: clears transmitter and receiver state, line levels idle high,
// the baud divisor returns to 1667.
// ----------------------------------------------------------------------------
module uart_8n1_tx_rx (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  u8tr_pkg::t_in_item   i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output u8tr_pkg::t_out_item  o_data
);
    import u8tr_pkg::*;

    t_out_item r_out;
    t_out_item r_skid;
    logic      r_out_vld;
    logic      r_skid_vld;
    t_out_item step_result;
    logic      accept;
    logic      taken;

    assign o_ready = !r_skid_vld;
    assign accept  = i_valid && o_ready;
    assign taken   = r_out_vld && i_ready;
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    u8tr_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_step     (accept),
        .i_item     (i_data),
        .o_result   (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (taken && r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else if (accept && (!r_out_vld || taken)) begin
                r_out_vld <= 1'b1;
            end else if (accept) begin
                r_skid_vld <= 1'b1;
            end else if (taken) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (taken && r_skid_vld) begin
            r_out <= r_skid;
        end else if (accept && (!r_out_vld || taken)) begin
            r_out <= step_result;
        end
        if (accept && r_out_vld && !taken) begin
            r_skid <= step_result;
        end
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry held without an output entry");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_out_vld && !i_ready) |=> r_skid_vld)
        else $error("transaction accepted during stall was not buffered");

    a_rx_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.rx_valid) |-> (r_out.rx_byte == 8'd0))
        else $error("rx byte nonzero without rx valid");

endmodule
